>>> rtl/core/gcode_line_numbering_framer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line framer
// Clock clk and reset arst_n are taken from the module that uses them.
// ----------------------------------------------------------------------------
`ifndef GCODE_LINE_NUMBERING_FRAMER_ASSERT_SVH
`define GCODE_LINE_NUMBERING_FRAMER_ASSERT_SVH

// Same-cycle implication.
`define GLNF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GLNF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/glnf_pkg.sv
// ----------------------------------------------------------------------------
// glnf_pkg
// Shared constants, the job record and BCD helpers for the line framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package glnf_pkg;

	localparam int CODE_HOLD  = 5;
	localparam int HCNT_W     = $clog2(CODE_HOLD + 1);
	localparam int HIDX_W     = $clog2(CODE_HOLD);
	localparam int LINE_W     = 14;
	localparam int BCD_DIGITS = 5;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int CK_BCD_W   = 12;
	localparam int IDX_W      = 3;
	localparam int RENUM_LEN  = 8;
	localparam int JOBQ_DEPTH = 4;
	localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

	localparam logic [LINE_W-1:0] LINE_MAX       = '1;
	localparam logic [LINE_W-1:0] LINE_RESET     = 14'd1;
	localparam logic [BCD_W-1:0]  LINE_RESET_BCD = 20'h00001;
	localparam logic [LINE_W-1:0] LIMIT_RESET    = 14'd10000;

	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_N     = 8'h4e;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic [31:0] CODE_M110 = "M110";
	localparam logic [31:0] CODE_M999 = "M999";

	// One accepted command byte, as the sequencer needs it
	typedef struct packed {
		logic                         ins;
		logic                         resolve;
		logic                         numbered;
		logic [LINE_W-1:0]            line_bin;
		logic [BCD_W-1:0]             line_bcd;
		logic [CODE_HOLD-1:0][7:0]    held;
		logic [HCNT_W-1:0]            held_cnt;
		logic                         has_text;
		logic [7:0]                   text;
		logic                         fin;
	} job_t;

	// Bytes of the renumbering line "M110 N0\n"
	function automatic logic [7:0] renum_byte(input logic [IDX_W-1:0] i);
		logic [7:0] b;
		unique case (i)
			3'd0: b = 8'h4d;
			3'd1: b = 8'h31;
			3'd2: b = 8'h31;
			3'd3: b = 8'h30;
			3'd4: b = CH_SPACE;
			3'd5: b = CH_N;
			3'd6: b = 8'h30;
			3'd7: b = CH_NL;
		endcase
		return b;
	endfunction

	// Add three to every digit of five or more (one double-dabble step)
	function automatic logic [BCD_W-1:0] bcd_dab(input logic [BCD_W-1:0] v);
		logic [BCD_W-1:0] r;
		r = v;
		for (int k = 0; k < BCD_DIGITS; k++) begin
			if (v[4*k +: 4] >= 4'd5) begin
				r[4*k +: 4] = v[4*k +: 4] + 4'd3;
			end
		end
		return r;
	endfunction

	function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
		logic [BCD_W-1:0] r;
		logic             carry;
		r     = v;
		carry = 1'b1;
		for (int k = 0; k < BCD_DIGITS; k++) begin
			if (carry) begin
				if (v[4*k +: 4] == 4'd9) begin
					r[4*k +: 4] = 4'd0;
				end else begin
					r[4*k +: 4] = v[4*k +: 4] + 4'd1;
					carry       = 1'b0;
				end
			end
		end
		return r;
	endfunction

	// Index of the most significant nonzero digit, zero for a zero value
	function automatic logic [IDX_W-1:0] bcd_top(input logic [BCD_W-1:0] v);
		logic [IDX_W-1:0] top;
		top = '0;
		for (int k = 1; k < BCD_DIGITS; k++) begin
			if (v[4*k +: 4] != 4'd0) begin
				top = IDX_W'(k);
			end
		end
		return top;
	endfunction

	function automatic logic [3:0] bcd_digit(input logic [BCD_W-1:0] v,
			input logic [IDX_W-1:0] idx);
		logic [3:0] d;
		d = 4'd0;
		for (int k = 0; k < BCD_DIGITS; k++) begin
			if (idx == IDX_W'(k)) begin
				d = v[4*k +: 4];
			end
		end
		return d;
	endfunction

	// Checksum byte to three BCD digits, eight narrow shift steps
	function automatic logic [CK_BCD_W-1:0] bin8_to_bcd(input logic [7:0] v);
		logic [CK_BCD_W-1:0] r;
		r = '0;
		for (int i = 7; i >= 0; i--) begin
			for (int k = 0; k < CK_BCD_W / 4; k++) begin
				if (r[4*k +: 4] >= 4'd5) begin
					r[4*k +: 4] = r[4*k +: 4] + 4'd3;
				end
			end
			r = {r[CK_BCD_W-2:0], v[i]};
		end
		return r;
	endfunction

endpackage

>>> rtl/core/glnf_front.sv
// ----------------------------------------------------------------------------
// glnf_front
// Classifies command bytes, holds the code and owns the line counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glnf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          action,
	input  logic [7:0]                    data_byte,
	input  logic                          final_byte,
	input  logic [glnf_pkg::LINE_W-1:0]   line_value,
	input  logic [glnf_pkg::LINE_W-1:0]   line_limit,
	output logic                          busy,
	output logic                          job_valid,
	output glnf_pkg::job_t                job
);
	import glnf_pkg::*;

	localparam int CONV_W = $clog2(LINE_W + 1);

	logic [LINE_W-1:0]         next_bin_q;
	logic [BCD_W-1:0]          next_bcd_q;
	logic [7:0]                held_q [CODE_HOLD];
	logic [HCNT_W-1:0]         held_cnt_q;
	logic                      resolved_q;
	logic                      in_cmd_q;
	logic [LINE_W-1:0]         sh_q;
	logic [CONV_W-1:0]         conv_cnt_q;

	logic                      starting;
	logic                      ins;
	logic [LINE_W-1:0]         nl_bin;
	logic [BCD_W-1:0]          nl_bcd;
	logic [HCNT_W-1:0]         cnt_eff;
	logic [HCNT_W-1:0]         cnt_inc;
	logic [HCNT_W-1:0]         cnt_job;
	logic                      res_eff;
	logic                      is_space;
	logic                      resolve;
	logic                      has_text;
	logic                      numbered;
	logic [CODE_HOLD-1:0][7:0] held_now;
	logic [31:0]               code4;
	logic [BCD_W-1:0]          dab;
	logic                      cmd_acc;

	assign busy    = conv_cnt_q != '0;
	assign cmd_acc = accept && !action;

	always_comb begin
		starting = !in_cmd_q;
		ins      = starting && (next_bin_q >= line_limit);
		nl_bin   = ins ? LINE_RESET : next_bin_q;
		nl_bcd   = ins ? LINE_RESET_BCD : next_bcd_q;
		cnt_eff  = starting ? '0 : held_cnt_q;
		res_eff  = starting ? 1'b0 : resolved_q;
		is_space = data_byte == CH_SPACE;
		cnt_inc  = cnt_eff + HCNT_W'(1);
		for (int i = 0; i < CODE_HOLD; i++) begin
			held_now[i] = (cnt_eff == HCNT_W'(i)) ? data_byte : held_q[i];
		end
		if (res_eff) begin
			resolve  = 1'b0;
			has_text = 1'b1;
			cnt_job  = cnt_eff;
		end else if (is_space) begin
			resolve  = 1'b1;
			has_text = 1'b1;
			cnt_job  = cnt_eff;
		end else begin
			resolve  = final_byte || (cnt_inc >= HCNT_W'(CODE_HOLD));
			has_text = 1'b0;
			cnt_job  = cnt_inc;
		end
		code4    = {held_now[0], held_now[1], held_now[2], held_now[3]};
		numbered = !((cnt_job == HCNT_W'(4)) && ((code4 == CODE_M110) || (code4 == CODE_M999)));
		dab      = bcd_dab(next_bcd_q);
	end

	always_comb begin
		job          = '0;
		job.ins      = ins;
		job.resolve  = resolve;
		job.numbered = numbered;
		job.line_bin = nl_bin;
		job.line_bcd = nl_bcd;
		job.held     = held_now;
		job.held_cnt = cnt_job;
		job.has_text = has_text;
		job.text     = data_byte;
		job.fin      = final_byte;
		job_valid    = cmd_acc && (ins || resolve || has_text);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_bin_q <= LINE_RESET;
			next_bcd_q <= LINE_RESET_BCD;
			held_cnt_q <= '0;
			resolved_q <= 1'b0;
			in_cmd_q   <= 1'b0;
			conv_cnt_q <= '0;
		end else if (accept && action) begin
			// load: binary now, decimal over LINE_W shift steps
			next_bin_q <= line_value;
			next_bcd_q <= '0;
			conv_cnt_q <= CONV_W'(LINE_W);
		end else if (busy) begin
			next_bcd_q <= {dab[BCD_W-2:0], sh_q[LINE_W-1]};
			conv_cnt_q <= conv_cnt_q - CONV_W'(1);
		end else if (cmd_acc) begin
			if (resolve && numbered) begin
				next_bin_q <= nl_bin + LINE_W'(1);
				next_bcd_q <= (nl_bin == LINE_MAX) ? '0 : bcd_inc(nl_bcd);
			end else if (ins) begin
				next_bin_q <= nl_bin;
				next_bcd_q <= nl_bcd;
			end
			in_cmd_q   <= !final_byte;
			resolved_q <= res_eff || resolve;
			held_cnt_q <= cnt_job;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && action) begin
			sh_q <= line_value;
		end else if (busy) begin
			sh_q <= {sh_q[LINE_W-2:0], 1'b0};
		end
		if (cmd_acc && !res_eff && !is_space) begin
			held_q[cnt_eff[HIDX_W-1:0]] <= data_byte;
		end
	end

endmodule

>>> rtl/core/glnf_jobq.sv
// ----------------------------------------------------------------------------
// glnf_jobq
// Short job queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glnf_jobq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  glnf_pkg::job_t din,
	output logic           full,
	input  logic           pop,
	output glnf_pkg::job_t dout,
	output logic           empty
);
	import glnf_pkg::*;

	job_t               slot_q [JOBQ_DEPTH];
	logic [JOBQ_AW-1:0] wr_q;
	logic [JOBQ_AW-1:0] rd_q;
	logic [JOBQ_AW:0]   cnt_q;

	assign full  = cnt_q == (JOBQ_AW + 1)'(JOBQ_DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + JOBQ_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + JOBQ_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (JOBQ_AW + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (JOBQ_AW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= din;
		end
	end

endmodule

>>> rtl/core/glnf_back.sv
// ----------------------------------------------------------------------------
// glnf_back
// Byte sequencer: expands jobs into framed output bytes and the checksum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glnf_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_empty,
	input  glnf_pkg::job_t               job,
	output logic                         job_pop,
	output logic                         empty,
	input  logic                         pop,
	output logic [7:0]                   out_byte,
	output logic                         line_end,
	output logic                         numbered,
	output logic [glnf_pkg::LINE_W-1:0]  line_number,
	output logic                         inserted,
	output logic                         run_last
);
	import glnf_pkg::*;

	`include "gcode_line_numbering_framer_assert.svh"

	typedef enum logic [3:0] {
		S_IDLE, S_INS, S_PN, S_PDIG, S_PSP, S_HELD, S_TEXT,
		S_FSP, S_FSTAR, S_FDIG, S_FNL
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    idx_q;
	job_t                cur_q;
	logic                num_q;
	logic [LINE_W-1:0]   line_q;
	logic [7:0]          xor_q;
	logic                star_q;
	logic [CK_BCD_W-1:0] ck_q;
	logic                ob_valid_q;

	logic                step;
	logic [7:0]          ebyte;
	logic                last_elem;
	logic                is_text;
	state_t              nxt;
	logic [IDX_W-1:0]    nxt_idx;
	logic [CK_BCD_W-1:0] ck_new;
	logic                hd_num;
	state_t              hd_state;
	logic [IDX_W-1:0]    hd_idx;

	// Next phase once state s has sent its last byte
	function automatic state_t seq_after(input state_t s, input job_t j, input logic num);
		state_t e_fin, e_text, e_held, e_pfx, r;
		e_fin  = num ? S_FSP : S_FNL;
		e_text = j.has_text ? S_TEXT : (j.fin ? e_fin : S_IDLE);
		e_held = (j.resolve && (j.held_cnt != '0)) ? S_HELD : e_text;
		e_pfx  = (j.resolve && num) ? S_PN : e_held;
		unique case (s)
			S_IDLE:  r = j.ins ? S_INS : e_pfx;
			S_INS:   r = e_pfx;
			S_PN:    r = S_PDIG;
			S_PDIG:  r = S_PSP;
			S_PSP:   r = e_held;
			S_HELD:  r = e_text;
			S_TEXT:  r = j.fin ? e_fin : S_IDLE;
			S_FSP:   r = S_FSTAR;
			S_FSTAR: r = S_FDIG;
			S_FDIG:  r = S_FNL;
			S_FNL:   r = S_IDLE;
			default: r = S_IDLE;
		endcase
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] init_idx(input state_t s, input job_t j,
			input logic [CK_BCD_W-1:0] ck);
		logic [IDX_W-1:0] r;
		priority case (s)
			S_PDIG:  r = bcd_top(j.line_bcd);
			S_FDIG:  r = bcd_top(BCD_W'(ck));
			default: r = '0;
		endcase
		return r;
	endfunction

	assign step    = !ob_valid_q || pop;
	assign empty   = !ob_valid_q;
	assign job_pop = (state_q == S_IDLE) && !job_empty;
	assign ck_new  = bin8_to_bcd(xor_q);

	always_comb begin
		hd_num   = job.resolve ? job.numbered : num_q;
		hd_state = seq_after(S_IDLE, job, hd_num);
		hd_idx   = init_idx(hd_state, job, ck_q);
	end

	always_comb begin
		ebyte     = CH_NL;
		last_elem = 1'b1;
		is_text   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				last_elem = 1'b0;
			end
			S_INS: begin
				ebyte     = renum_byte(idx_q);
				last_elem = idx_q == IDX_W'(RENUM_LEN - 1);
			end
			S_PN: begin
				ebyte   = CH_N;
				is_text = 1'b1;
			end
			S_PDIG: begin
				ebyte     = CH_ZERO | {4'd0, bcd_digit(cur_q.line_bcd, idx_q)};
				last_elem = idx_q == '0;
				is_text   = 1'b1;
			end
			S_PSP: begin
				ebyte   = CH_SPACE;
				is_text = 1'b1;
			end
			S_HELD: begin
				ebyte     = cur_q.held[idx_q[HIDX_W-1:0]];
				last_elem = (HCNT_W'(idx_q) + HCNT_W'(1)) == cur_q.held_cnt;
				is_text   = 1'b1;
			end
			S_TEXT: begin
				ebyte   = cur_q.text;
				is_text = 1'b1;
			end
			S_FSP: begin
				ebyte   = CH_SPACE;
				is_text = 1'b1;
			end
			S_FSTAR: begin
				ebyte = CH_STAR;
			end
			S_FDIG: begin
				ebyte     = CH_ZERO | {4'd0, bcd_digit(BCD_W'(ck_q), idx_q)};
				last_elem = idx_q == '0;
			end
			S_FNL: begin
				ebyte = CH_NL;
			end
			default: begin
				last_elem = 1'b0;
			end
		endcase
		nxt     = last_elem ? seq_after(state_q, cur_q, num_q) : state_q;
		nxt_idx = init_idx(nxt, cur_q, ck_new);
		if (!last_elem) begin
			// walk digits downward, byte strings upward
			nxt_idx = ((state_q == S_PDIG) || (state_q == S_FDIG)) ?
				idx_q - IDX_W'(1) : idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			cur_q       <= '0;
			num_q       <= 1'b0;
			line_q      <= '0;
			xor_q       <= '0;
			star_q      <= 1'b0;
			ck_q        <= '0;
			ob_valid_q  <= 1'b0;
			out_byte    <= '0;
			line_end    <= 1'b0;
			numbered    <= 1'b0;
			line_number <= '0;
			inserted    <= 1'b0;
			run_last    <= 1'b0;
		end else if (state_q == S_IDLE) begin
			if (pop) begin
				ob_valid_q <= 1'b0;
			end
			if (!job_empty) begin
				cur_q   <= job;
				state_q <= hd_state;
				idx_q   <= hd_idx;
				if (job.resolve) begin
					// a command's checksum starts with its prefix
					xor_q  <= '0;
					star_q <= 1'b0;
					num_q  <= job.numbered;
					line_q <= job.line_bin;
				end
			end
		end else if (step) begin
			ob_valid_q  <= 1'b1;
			out_byte    <= ebyte;
			line_end    <= (state_q == S_FNL) || ((state_q == S_INS) && last_elem);
			inserted    <= state_q == S_INS;
			numbered    <= (state_q != S_INS) && num_q;
			line_number <= ((state_q != S_INS) && num_q) ? line_q : '0;
			run_last    <= last_elem && (nxt == S_IDLE);
			state_q     <= nxt;
			idx_q       <= nxt_idx;
			if (state_q == S_FSTAR) begin
				ck_q <= ck_new;
			end
			if (is_text && !star_q) begin
				if (ebyte == CH_STAR) begin
					star_q <= 1'b1;
				end else begin
					xor_q <= xor_q ^ ebyte;
				end
			end
		end
	end

	`GLNF_ASSERT_IMP(a_ins_unnumbered, !empty && inserted, !numbered && (line_number == '0), "inserted line carries a number")
	`GLNF_ASSERT_NXT(a_star_then_digit, (state_q == S_FSTAR) && step, state_q == S_FDIG, "checksum digits do not follow star")
	`GLNF_ASSERT_IMP(a_held_in_range, state_q == S_HELD, HCNT_W'(idx_q) < cur_q.held_cnt, "held byte index past held count")

endmodule

>>> rtl/core/gcode_line_numbering_framer.sv
// ----------------------------------------------------------------------------
// gcode_line_numbering_framer
// Latency: a command byte's job is written into the job queue, then taken
// into the sequencer's state, and its first result is registered on the result ports.
// Throughput: one result per cycle within a job while the consumer pops,
// plus a start step in the idle state for each job; a line-number load holds
// full high while the decimal copy of the counter is rebuilt.
// Reset: arst_n clears all control state at once; there is no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcode_line_numbering_framer (
	input  logic                         clk,
	input  logic                         arst_n,
	// input queue side
	input  logic                         push,
	output logic                         full,
	input  logic                         action,
	input  logic [7:0]                   data_byte,
	input  logic                         final_byte,
	input  logic [glnf_pkg::LINE_W-1:0]  line_value,
	// register write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [glnf_pkg::LINE_W-1:0]  cfg_data,
	// result queue side
	output logic                         empty,
	input  logic                         pop,
	output logic [7:0]                   out_byte,
	output logic                         line_end,
	output logic                         numbered,
	output logic [glnf_pkg::LINE_W-1:0]  line_number,
	output logic                         inserted,
	output logic                         run_last
);
	import glnf_pkg::*;

	// The front end classifies each byte as soon as it arrives: it holds the
	// first bytes of a line until the code is known, decides whether the line
	// is numbered, and keeps the line counter in binary and in BCD so the
	// sequencer never has to divide. Its decisions travel as one job record.
	// The back end turns each job into the renumbering line, the "N<line> "
	// prefix, held bytes, text, and the " *<checksum>\n" trailer.

	logic [LINE_W-1:0] line_limit_q;
	logic              accept;
	logic              front_busy;
	logic              job_valid;
	job_t              front_job;
	logic              q_full;
	logic              q_empty;
	logic              q_pop;
	job_t              q_job;

	// Transfer an item whenever the decoder is not rebuilding the counter
	// and the job queue has room.
	assign full      = front_busy || q_full;
	assign accept    = push && !full;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			line_limit_q <= cfg_data;
		end
	end

	glnf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.action     (action),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.line_value (line_value),
		.line_limit (line_limit_q),
		.busy       (front_busy),
		.job_valid  (job_valid),
		.job        (front_job)
	);

	// Jobs that produce no bytes (loads, held code bytes) never enter here.
	glnf_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_valid),
		.din    (front_job),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_job),
		.empty  (q_empty)
	);

	// Output register inside the sequencer parts it from the consumer.
	glnf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_empty   (q_empty),
		.job         (q_job),
		.job_pop     (q_pop),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.line_end    (line_end),
		.numbered    (numbered),
		.line_number (line_number),
		.inserted    (inserted),
		.run_last    (run_last)
	);

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the G-code line framer. A behavioral copy of the
// framer predicts every output byte of each command transfer; a result sink
// pops the output queue with random stalls and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import glnf_pkg::*;

	// Item kinds on the action field
	typedef enum logic {
		ACT_BYTE = 1'b0,
		ACT_LOAD = 1'b1
	} act_t;

	// One output byte as the framer should present it
	typedef struct packed {
		logic [7:0]        ch;
		logic              eol;
		logic              numb;
		logic [LINE_W-1:0] lnum;
		logic              ins;
		logic              last;
	} frame_rec_t;

	localparam int WATCHDOG_LIMIT = 2000;
	// Padding after the last owed byte, so a trailing load's stall can finish
	localparam int SETTLE_CYCLES  = 24;
	localparam int HOLD_CYCLES    = 150;
	// Inserted renumbering line, first byte in the top bits
	localparam logic [63:0] RENUM_TEXT = {"M110 N0", 8'h0a};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic              action = 1'b0;
	logic [7:0]        data_byte = 8'h00;
	logic              final_byte = 1'b0;
	logic [LINE_W-1:0] line_value = '0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [LINE_W-1:0] cfg_data = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [7:0]        out_byte;
	logic              line_end;
	logic              numbered;
	logic [LINE_W-1:0] line_number;
	logic              inserted;
	logic              run_last;

	gcode_line_numbering_framer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.action      (action),
		.data_byte   (data_byte),
		.final_byte  (final_byte),
		.line_value  (line_value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.line_end    (line_end),
		.numbered    (numbered),
		.line_number (line_number),
		.inserted    (inserted),
		.run_last    (run_last)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Framer prediction state, kept in step with every accepted transfer
	// ------------------------------------------------------------------
	logic [LINE_W-1:0] lim_reg = LIMIT_RESET;
	logic [LINE_W-1:0] nxt_line_no = LINE_RESET;
	logic [LINE_W-1:0] cur_line_no = '0;
	logic [7:0]        code_buf [CODE_HOLD];
	int                code_len = 0;
	bit                code_done = 1'b0;
	bit                num_line = 1'b0;
	logic [7:0]        ck_xor = 8'h00;
	bit                star_hit = 1'b0;
	bit                mid_cmd = 1'b0;

	frame_rec_t frame_q[$];   // bytes still owed by the framer, oldest first
	frame_rec_t step_q[$];    // bytes caused by the transfer being predicted

	int  errors = 0;
	int  items_sent = 0;
	int  results_seen = 0;
	int  cfg_writes = 0;
	int  renum_lines = 0;
	bit  burst_mode = 1'b0;   // no idle cycles on either side while set
	int  hold_req = 0;        // long pop hold-off requested from the sink

	task automatic put_raw(input logic [7:0] b, input logic eol, input logic ins);
		frame_rec_t r;
		r.ch   = b;
		r.eol  = eol;
		r.numb = !ins && num_line;
		r.lnum = (!ins && num_line) ? cur_line_no : '0;
		r.ins  = ins;
		r.last = 1'b0;
		step_q.insert(step_q.size(), r);
	endtask

	// Command text: emit and fold into the checksum up to the first star
	task automatic put_text(input logic [7:0] b);
		put_raw(b, 1'b0, 1'b0);
		if (!star_hit) begin
			if (b == CH_STAR)
				star_hit = 1'b1;
			else
				ck_xor ^= b;
		end
	endtask

	task automatic put_decimal(input int unsigned v, input bit to_sum);
		logic [7:0] dig [6];
		int         k;
		k = 0;
		do begin
			dig[k] = 8'(CH_ZERO + v % 10);
			v      = v / 10;
			k++;
		end while (v != 0 && k < 6);
		while (k > 0) begin
			k--;
			if (to_sum)
				put_text(dig[k]);
			else
				put_raw(dig[k], 1'b0, 1'b0);
		end
	endtask

	// Code is known: decide numbering, emit the prefix, release held bytes
	task automatic resolve_code();
		logic [31:0] code4;
		bit          plain;
		code4     = {code_buf[0], code_buf[1], code_buf[2], code_buf[3]};
		plain     = (code_len == 4) && (code4 == CODE_M110 || code4 == CODE_M999);
		code_done = 1'b1;
		num_line  = !plain;
		if (num_line) begin
			cur_line_no = nxt_line_no;
			nxt_line_no = nxt_line_no + 1'b1;
			put_text(CH_N);
			put_decimal(cur_line_no, 1'b1);
			put_text(CH_SPACE);
		end
		for (int i = 0; i < code_len; i++)
			put_text(code_buf[i]);
	endtask

	task automatic frame_predict(input act_t act, input logic [7:0] b, input logic fin,
			input logic [LINE_W-1:0] lv);
		frame_rec_t r;
		if (act == ACT_LOAD) begin
			// Load only retargets the counter; an unresolved line picks it up
			nxt_line_no = lv;
			return;
		end
		if (!mid_cmd) begin
			if (nxt_line_no >= lim_reg) begin
				for (int i = 0; i < 8; i++)
					put_raw(RENUM_TEXT[63 - 8*i -: 8], i == 7, 1'b1);
				nxt_line_no = LINE_RESET;
			end
			mid_cmd   = 1'b1;
			code_len  = 0;
			code_done = 1'b0;
			num_line  = 1'b0;
			ck_xor    = 8'h00;
			star_hit  = 1'b0;
		end
		if (!code_done) begin
			if (b == CH_SPACE) begin
				resolve_code();
				put_text(b);
			end else begin
				if (code_len < CODE_HOLD) begin
					code_buf[code_len] = b;
					code_len++;
				end
				if (fin || code_len >= CODE_HOLD)
					resolve_code();
			end
		end else begin
			put_text(b);
		end
		if (fin) begin
			if (num_line) begin
				put_text(CH_SPACE);
				put_raw(CH_STAR, 1'b0, 1'b0);
				put_decimal(ck_xor, 1'b0);
			end
			put_raw(CH_NL, 1'b1, 1'b0);
			mid_cmd = 1'b0;
		end
		// Flag the last byte of this transfer and queue the lot
		for (int i = 0; i < step_q.size(); i++) begin
			r      = step_q[i];
			r.last = (i == step_q.size() - 1);
			frame_q.insert(frame_q.size(), r);
		end
		step_q.delete();
	endtask

	// ------------------------------------------------------------------
	// Input side: idle a random number of cycles, then hold push until
	// the transfer happens
	// ------------------------------------------------------------------
	task automatic send_item(input act_t act, input logic [7:0] b, input logic fin,
			input logic [LINE_W-1:0] lv);
		int unsigned gap;
		gap = burst_mode ? 0 : $urandom_range(0, 7);
		repeat (gap) begin
			@(negedge clk);
			push      <= 1'b0;
			data_byte <= 8'($urandom_range(0, 255));
		end
		@(negedge clk);
		push       <= 1'b1;
		action     <= act;
		data_byte  <= b;
		final_byte <= fin;
		line_value <= lv;
		do @(posedge clk); while (full);
		items_sent++;
		frame_predict(act, b, fin, lv);
	endtask

	task automatic send_text(input string s, input bit fin);
		for (int i = 0; i < s.len(); i++)
			send_item(ACT_BYTE, 8'(s[i]), fin && (i == s.len() - 1), '0);
	endtask

	// Drop push, let every owed byte arrive, then cover a trailing load
	task automatic wait_drained();
		@(negedge clk);
		push <= 1'b0;
		while (frame_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called with the framer idle
	task automatic write_line_limit(input logic [LINE_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		lim_reg = v;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Bias loads toward the limit so renumbering lines show up
	function automatic logic [LINE_W-1:0] pick_line_value();
		case ($urandom_range(0, 3))
			0: return 14'($urandom_range(0, 10000));
			1: return (lim_reg == 0) ? '0 : lim_reg - 1'b1;
			2: return lim_reg;
			default: return 14'($urandom_range(0, 20));
		endcase
	endfunction

	// One random command line, mostly well formed, with loads sprinkled in
	task automatic send_command();
		logic [7:0] text_q[$];
		string      code_s;
		int         sel;
		int         r;
		sel    = $urandom_range(0, 9);
		code_s = "";
		case (sel)
			0: code_s = "M110";
			1: code_s = "M999";
			3: begin
				case ($urandom_range(0, 3))
					0: code_s = "M11";
					1: code_s = "M1100";
					2: code_s = "M99";
					default: code_s = "M9990";
				endcase
			end
			default: ;
		endcase
		for (int i = 0; i < code_s.len(); i++)
			text_q.insert(text_q.size(), 8'(code_s[i]));
		if (sel == 4) begin
			repeat ($urandom_range(5, 7))
				text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
		end else if (sel >= 5) begin
			case ($urandom_range(0, 2))
				0: text_q.insert(text_q.size(), "G");
				1: text_q.insert(text_q.size(), "M");
				default: text_q.insert(text_q.size(), "T");
			endcase
			repeat ($urandom_range(1, 3))
				text_q.insert(text_q.size(), 8'(CH_ZERO + $urandom_range(0, 9)));
		end
		// Empty code always gets the space; others usually carry arguments
		if (sel == 2 || $urandom_range(0, 3) != 0) begin
			text_q.insert(text_q.size(), CH_SPACE);
			repeat ($urandom_range(0, 6)) begin
				r = $urandom_range(0, 7);
				if (r == 0)
					text_q.insert(text_q.size(), CH_STAR);
				else if (r == 1)
					text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
				else
					text_q.insert(text_q.size(), 8'($urandom_range(33, 126)));
			end
		end
		if ($urandom_range(0, 5) == 0)
			send_item(ACT_LOAD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				pick_line_value());
		foreach (text_q[i]) begin
			if ($urandom_range(0, 11) == 0)
				send_item(ACT_LOAD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					pick_line_value());
			send_item(ACT_BYTE, text_q[i], i == text_q.size() - 1,
				14'($urandom_range(0, 10000)));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-picked lines at the reset limit of 10000
	task automatic test_directed();
		// Line zero, then a code that resolves on the final byte
		send_item(ACT_LOAD, 8'h00, 1'b0, '0);
		send_text("G28", 1'b1);
		// Pass-through codes, one ended by a space, one by the final byte
		send_text("M110 ", 1'b1);
		send_text("M999", 1'b1);
		// Five held bytes force resolution; extremes, newline and a star in the code
		send_item(ACT_BYTE, 8'h00, 1'b0, '1);
		send_item(ACT_BYTE, 8'hff, 1'b0, '0);
		send_item(ACT_BYTE, CH_NL, 1'b0, '1);
		send_item(ACT_BYTE, CH_STAR, 1'b0, '0);
		send_item(ACT_BYTE, 8'h01, 1'b0, '1);
		send_item(ACT_BYTE, 8'h7f, 1'b1, '0);
		// Load while the code is still held: the line takes the new number
		send_text("G", 1'b0);
		send_item(ACT_LOAD, 8'hff, 1'b1, 14'd9999);
		send_text("1", 1'b1);
		// Counter now at the limit: renumber, empty code, load after the prefix
		send_text(" ", 1'b0);
		send_item(ACT_LOAD, 8'h00, 1'b0, 14'd7);
		send_text("Z", 1'b1);
	endtask

	// Smallest legal limit and the two degenerate ones
	task automatic test_limit_extremes();
		logic [LINE_W-1:0] lims [3];
		lims = '{14'd2, 14'd1, 14'd0};
		foreach (lims[i]) begin
			wait_drained();
			write_line_limit(lims[i]);
			repeat (3) send_command();
		end
	endtask

	// Bulk random lines over several limits, one phase with no idling
	task automatic test_random_lines();
		logic [LINE_W-1:0] lims [4];
		int                goal;
		lims = '{14'd10000, 14'd3, 14'($urandom_range(2, 40)), 14'($urandom_range(2, 10000))};
		foreach (lims[i]) begin
			wait_drained();
			write_line_limit(lims[i]);
			burst_mode = (i == 2);
			goal       = items_sent + 30;
			while (items_sent < goal)
				send_command();
			burst_mode = 1'b0;
		end
	endtask

	// Sink holds off while the source streams, so the framer fills and stalls
	task automatic test_receiver_hold();
		int goal;
		wait_drained();
		hold_req   = HOLD_CYCLES;
		burst_mode = 1'b1;
		goal       = items_sent + 40;
		while (items_sent < goal)
			send_command();
		burst_mode = 1'b0;
	endtask

	// Source stops mid-line until everything owed has come out
	task automatic test_sender_pause();
		send_text("G1 X", 1'b0);
		wait_drained();
		send_text("5", 1'b1);
		send_text("M11", 1'b0);
		wait_drained();
		send_text("0", 1'b1);
		send_text("T", 1'b0);
		wait_drained();
		send_text("12", 1'b1);
	endtask

	// ------------------------------------------------------------------
	// Result sink and checker
	// ------------------------------------------------------------------
	task automatic check_field(input string fname, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname,
				want, got);
		end
	endtask

	initial begin : result_sink
		int unsigned w;
		frame_rec_t  e;
		@(posedge arst_n);
		forever begin
			w = burst_mode ? 0 : $urandom_range(0, 7);
			if (hold_req != 0) begin
				w        = hold_req;
				hold_req = 0;
			end
			repeat (w) begin
				@(negedge clk);
				pop <= 1'b0;
			end
			@(negedge clk);
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			results_seen++;
			if (line_end && inserted)
				renum_lines++;
			if (frame_q.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected result, expected none, actual byte %0d",
					$time, out_byte);
			end else begin
				e = frame_q[0];
				frame_q.delete(0);
				check_field("out_byte", e.ch, out_byte);
				check_field("line_end", e.eol, line_end);
				check_field("numbered", e.numb, numbered);
				check_field("line_number", e.lnum, line_number);
				check_field("inserted", e.ins, inserted);
				check_field("run_last", e.last, run_last);
			end
		end
	end

	// Abort when nothing moves on any channel for too long
	int stall_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("%0t ns: no transfer for %0d cycles, %0d bytes still owed", $time,
				WATCHDOG_LIMIT, frame_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_line_limit(LIMIT_RESET);
		test_directed();
		test_limit_extremes();
		test_random_lines();
		test_receiver_hold();
		test_sender_pause();
		wait_drained();

		if (frame_q.size() != 0) begin
			errors += frame_q.size();
			$display("%0t ns: %0d expected bytes never arrived", $time, frame_q.size());
		end
		$display("Sent %0d items over %0d line-limit writes; checked %0d output bytes,",
			items_sent, cfg_writes, results_seen);
		$display("including %0d renumbering lines, with %0d mismatches.", renum_lines, errors);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> gcode_line_numbering_framer.f
+incdir+rtl/core
rtl/core/glnf_pkg.sv
rtl/core/glnf_front.sv
rtl/core/glnf_jobq.sv
rtl/core/glnf_back.sv
rtl/core/gcode_line_numbering_framer.sv
tb/sv/tb_top.sv
